[src/smbus_read_word_master_defines.svh]
// ----------------------------------------------------------------------------
// smbus_read_word_master assertion macros
// Concurrent check wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef SMBUS_READ_WORD_MASTER_DEFINES_SVH
`define SMBUS_READ_WORD_MASTER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SRWM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srwm check failed");
// next-cycle implication
`define SRWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srwm check failed");
`else
`define SRWM_ASSERT_IMP(label, clk, rst, ante, cons)
`define SRWM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/srwm_pkg.sv]
// ----------------------------------------------------------------------------
// srwm_pkg
// Types and constants of the SMBus read-word master.
// ----------------------------------------------------------------------------
`default_nettype none

package srwm_pkg;

  // waveform phase, one-hot
  typedef enum logic [10:0] {
    PH_IDLE = 11'b000_0000_0001,
    PH_SA   = 11'b000_0000_0010,
    PH_SB   = 11'b000_0000_0100,
    PH_SC   = 11'b000_0000_1000,
    PH_SD   = 11'b000_0001_0000,
    PH_BSET = 11'b000_0010_0000,
    PH_BHI  = 11'b000_0100_0000,
    PH_BLO  = 11'b000_1000_0000,
    PH_PA   = 11'b001_0000_0000,
    PH_PB   = 11'b010_0000_0000,
    PH_PC   = 11'b100_0000_0000
  } phase_t;

  // what follows a STOP
  typedef enum logic [1:0] {
    STOP_FINAL = 2'd0,
    STOP_RETRY = 2'd1,
    STOP_GOON  = 2'd2
  } stop_mode_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SLAVE_ADDRESS = 2'd0,
    CFG_COMMAND_CODE  = 2'd1,
    CFG_RETRY_LIMIT   = 2'd2,
    CFG_PHASE_TICKS   = 2'd3
  } cfg_index_t;

  localparam int CFG_DATA_W = 16;

  // byte positions in the transaction
  localparam logic [2:0] BYTE_ADDR_WR = 3'd0;
  localparam logic [2:0] BYTE_CMD     = 3'd1;
  localparam logic [2:0] BYTE_ADDR_RD = 3'd2;
  localparam logic [2:0] BYTE_LOW     = 3'd3;
  localparam logic [2:0] BYTE_HIGH    = 3'd4;
  localparam logic [2:0] BYTE_PEC     = 3'd5;
  localparam logic [2:0] BYTE_END     = 3'd6;

  // bit slot of the ACK after eight data bits
  localparam logic [3:0] BIT_ACK = 4'd8;

  // reset values of the registers
  localparam logic [6:0]  RST_SLAVE_ADDRESS = 7'h00;
  localparam logic [7:0]  RST_COMMAND_CODE  = 8'h07;
  localparam logic [7:0]  RST_RETRY_LIMIT   = 8'd10;
  localparam logic [15:0] RST_PHASE_TICKS   = 16'd100;

  // byte sent by the master at a given position
  function automatic logic [7:0] byte_value(input logic [2:0] idx, input logic [6:0] addr,
                                            input logic [7:0] cmd);
    logic [7:0] v;
    unique case (idx)
      BYTE_ADDR_WR: v = {addr, 1'b0};
      BYTE_CMD:     v = cmd;
      BYTE_ADDR_RD: v = {addr, 1'b1};
      default:      v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[src/smbus_read_word_master.sv]
// ----------------------------------------------------------------------------
// smbus_read_word_master
// Tick-driven SMBus read-word master (address, command, repeated START,
// three received bytes with PEC) with NACK retry.
// ----------------------------------------------------------------------------
// Each input transfer is one time-base tick carrying the sampled SDA level and
// a start request (tuser). For every tick the block returns exactly one output
// transfer with the SCL/SDA levels of that tick, busy, the last word and PEC
// read, and the NACK flag; tlast marks the tick on which the final STOP ends.
// A start request is taken only while idle. Every waveform phase lasts
// phase_ticks ticks (0 acts as 1; lengths beyond 2^PHASE_COUNT_WIDTH saturate).
// Throughput is one tick per clock unless the output side stalls: the whole
// sequencer step sits between the state and output registers, so a tick can
// be accepted every cycle and its result is registered in the cycle after.
// The single output register decouples the sides; input stalls only while a
// result waits and the output side is not ready. Configuration is written
// through cfg_we/cfg_index/cfg_data with no wait; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "smbus_read_word_master_defines.svh"

module smbus_read_word_master #(
  parameter int PHASE_COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input ticks
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] sda_in, [7:1] zero
  input  wire logic        s_axis_tuser,   // [0] command
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [0] scl_out, [1] sda_out, [2] busy_res,
                                           // [18:3] word_value, [26:19] pec_value,
                                           // [27] nack_seen, [31:28] zero
  output logic             m_axis_tlast,   // done_res
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [srwm_pkg::CFG_DATA_W-1:0] cfg_data
);

  // compare width wide enough for both the counter and the 16-bit phase length
  localparam int CMP_W = (PHASE_COUNT_WIDTH > 16) ? PHASE_COUNT_WIDTH : 16;

  // configuration registers
  logic [6:0]  slave_address;
  logic [7:0]  command_code;
  logic [7:0]  retry_limit;
  logic [15:0] phase_ticks;

  // sequencer state
  srwm_pkg::phase_t           phase;
  srwm_pkg::stop_mode_t       stop_mode;
  logic [PHASE_COUNT_WIDTH-1:0] tick_count;
  logic [3:0]  bit_index;
  logic [2:0]  byte_index;
  logic [7:0]  shift_reg;
  logic [7:0]  retries_left;
  logic [7:0]  low_byte;
  logic [7:0]  high_byte;
  logic [7:0]  pec_byte;
  logic        nack_flag;

  // next values
  srwm_pkg::phase_t           phase_next;
  srwm_pkg::stop_mode_t       stop_mode_next;
  logic [PHASE_COUNT_WIDTH-1:0] tick_count_next;
  logic [3:0]  bit_index_next;
  logic [2:0]  byte_index_next;
  logic [7:0]  shift_reg_next;
  logic [7:0]  retries_left_next;
  logic [7:0]  low_byte_next;
  logic [7:0]  high_byte_next;
  logic [7:0]  pec_byte_next;
  logic        nack_flag_next;

  // result of the current tick
  logic        res_scl;
  logic        res_sda;
  logic        res_busy;
  logic        res_done;
  logic        phase_end;
  logic        bit_level;
  logic [15:0] last_tick;

  logic        tick_cmd;
  logic        tick_sda;
  logic        s_accept;

  assign tick_cmd      = s_axis_tuser;
  assign tick_sda      = s_axis_tdata[0];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // last tick index of a phase; zero length acts as one tick
  assign last_tick = (phase_ticks == 16'd0) ? 16'd0 : 16'(phase_ticks - 16'd1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= srwm_pkg::RST_SLAVE_ADDRESS;
      command_code  <= srwm_pkg::RST_COMMAND_CODE;
      retry_limit   <= srwm_pkg::RST_RETRY_LIMIT;
      phase_ticks   <= srwm_pkg::RST_PHASE_TICKS;
    end else if (cfg_we) begin
      unique case (srwm_pkg::cfg_index_t'(cfg_index))
        srwm_pkg::CFG_SLAVE_ADDRESS: slave_address <= cfg_data[6:0];
        srwm_pkg::CFG_COMMAND_CODE:  command_code  <= cfg_data[7:0];
        srwm_pkg::CFG_RETRY_LIMIT:   retry_limit   <= cfg_data[7:0];
        srwm_pkg::CFG_PHASE_TICKS:   phase_ticks   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // one sequencer step per tick
  always_comb begin
    phase_next        = phase;
    stop_mode_next    = stop_mode;
    tick_count_next   = tick_count;
    bit_index_next    = bit_index;
    byte_index_next   = byte_index;
    shift_reg_next    = shift_reg;
    retries_left_next = retries_left;
    low_byte_next     = low_byte;
    high_byte_next    = high_byte;
    pec_byte_next     = pec_byte;
    nack_flag_next    = nack_flag;
    res_scl           = 1'b1;
    res_sda           = 1'b1;
    res_busy          = 1'b0;
    res_done          = 1'b0;
    phase_end         = 1'b0;
    bit_level         = 1'b1;

    // start request: the transaction begins on this very tick
    if (phase_next == srwm_pkg::PH_IDLE && tick_cmd) begin
      phase_next        = srwm_pkg::PH_SA;
      tick_count_next   = '0;
      byte_index_next   = srwm_pkg::BYTE_ADDR_WR;
      bit_index_next    = 4'd0;
      shift_reg_next    = 8'h00;
      retries_left_next = retry_limit;
      nack_flag_next    = 1'b0;
      stop_mode_next    = srwm_pkg::STOP_FINAL;
    end

    if (phase_next != srwm_pkg::PH_IDLE) begin
      // counter saturates at all ones, so that also ends an over-long phase
      phase_end = (CMP_W'(tick_count_next) >= CMP_W'(last_tick)) || (&tick_count_next);
      res_busy  = 1'b1;

      // data level during a bit slot
      if (byte_index_next < srwm_pkg::BYTE_LOW) begin
        bit_level = (bit_index_next < srwm_pkg::BIT_ACK) ? shift_reg_next[7] : 1'b1;
      end else if (bit_index_next < srwm_pkg::BIT_ACK) begin
        bit_level = 1'b1;
      end else begin
        // ACK low and high bytes, NACK the PEC
        bit_level = (byte_index_next == srwm_pkg::BYTE_PEC);
      end

      unique case (phase_next)
        srwm_pkg::PH_SA:   begin res_scl = 1'b0; res_sda = 1'b1; end
        srwm_pkg::PH_SB:   begin res_scl = 1'b1; res_sda = 1'b1; end
        srwm_pkg::PH_SC:   begin res_scl = 1'b1; res_sda = 1'b0; end
        srwm_pkg::PH_SD:   begin res_scl = 1'b0; res_sda = 1'b0; end
        srwm_pkg::PH_BSET: begin res_scl = 1'b0; res_sda = bit_level; end
        srwm_pkg::PH_BHI:  begin res_scl = 1'b1; res_sda = bit_level; end
        srwm_pkg::PH_BLO:  begin res_scl = 1'b0; res_sda = bit_level; end
        srwm_pkg::PH_PA:   begin res_scl = 1'b0; res_sda = 1'b0; end
        srwm_pkg::PH_PB:   begin res_scl = 1'b1; res_sda = 1'b0; end
        default: begin
          res_scl  = 1'b1;
          res_sda  = 1'b1;
          res_done = phase_end && (stop_mode_next == srwm_pkg::STOP_FINAL);
        end
      endcase

      if (!phase_end) begin
        tick_count_next = PHASE_COUNT_WIDTH'(tick_count_next + 1'b1);
      end else begin
        tick_count_next = '0;
        unique case (phase_next)
          srwm_pkg::PH_SA: phase_next = srwm_pkg::PH_SB;
          srwm_pkg::PH_SB: phase_next = srwm_pkg::PH_SC;
          srwm_pkg::PH_SC: phase_next = srwm_pkg::PH_SD;
          srwm_pkg::PH_SD: begin
            phase_next     = srwm_pkg::PH_BSET;
            bit_index_next = 4'd0;
            shift_reg_next = srwm_pkg::byte_value(byte_index_next, slave_address,
                                                  command_code);
          end
          srwm_pkg::PH_BSET: phase_next = srwm_pkg::PH_BHI;
          srwm_pkg::PH_BHI: begin
            // sample on the last tick of SCL high
            if (byte_index_next >= srwm_pkg::BYTE_LOW) begin
              if (bit_index_next < srwm_pkg::BIT_ACK) begin
                shift_reg_next = {shift_reg_next[6:0], tick_sda};
              end
            end else if (bit_index_next >= srwm_pkg::BIT_ACK) begin
              shift_reg_next = {7'd0, tick_sda};
            end
            phase_next = srwm_pkg::PH_BLO;
          end
          srwm_pkg::PH_BLO: begin
            if (bit_index_next < srwm_pkg::BIT_ACK) begin
              if (byte_index_next < srwm_pkg::BYTE_LOW) begin
                shift_reg_next = {shift_reg_next[6:0], 1'b0};
              end
              bit_index_next = 4'(bit_index_next + 4'd1);
              phase_next     = srwm_pkg::PH_BSET;
            end else if (byte_index_next >= srwm_pkg::BYTE_LOW) begin
              // received byte complete
              if (byte_index_next == srwm_pkg::BYTE_LOW) begin
                low_byte_next = shift_reg_next;
              end else if (byte_index_next == srwm_pkg::BYTE_HIGH) begin
                high_byte_next = shift_reg_next;
              end else begin
                pec_byte_next = shift_reg_next;
              end
              byte_index_next = 3'(byte_index_next + 3'd1);
              if (byte_index_next >= srwm_pkg::BYTE_END) begin
                stop_mode_next = srwm_pkg::STOP_FINAL;
                phase_next     = srwm_pkg::PH_PA;
              end else begin
                phase_next     = srwm_pkg::PH_BSET;
                bit_index_next = 4'd0;
                shift_reg_next = srwm_pkg::byte_value(byte_index_next, slave_address,
                                                      command_code);
              end
            end else if (!shift_reg_next[0]) begin
              // ACK: next byte, repeated START before the read address
              byte_index_next   = 3'(byte_index_next + 3'd1);
              retries_left_next = retry_limit;
              if (byte_index_next == srwm_pkg::BYTE_ADDR_RD) begin
                phase_next = srwm_pkg::PH_SA;
              end else begin
                phase_next     = srwm_pkg::PH_BSET;
                bit_index_next = 4'd0;
                shift_reg_next = srwm_pkg::byte_value(byte_index_next, slave_address,
                                                      command_code);
              end
            end else if (retries_left_next != 8'd0) begin
              // NACK, resend after STOP/START
              retries_left_next = 8'(retries_left_next - 8'd1);
              stop_mode_next    = srwm_pkg::STOP_RETRY;
              phase_next        = srwm_pkg::PH_PA;
            end else begin
              // NACK, out of retries: flag it and move on
              nack_flag_next    = 1'b1;
              byte_index_next   = 3'(byte_index_next + 3'd1);
              retries_left_next = retry_limit;
              stop_mode_next    = srwm_pkg::STOP_GOON;
              phase_next        = srwm_pkg::PH_PA;
            end
          end
          srwm_pkg::PH_PA: phase_next = srwm_pkg::PH_PB;
          srwm_pkg::PH_PB: phase_next = srwm_pkg::PH_PC;
          default: begin
            if (stop_mode_next == srwm_pkg::STOP_FINAL
                || byte_index_next >= srwm_pkg::BYTE_END) begin
              phase_next = srwm_pkg::PH_IDLE;
            end else if (stop_mode_next == srwm_pkg::STOP_GOON
                         && byte_index_next != srwm_pkg::BYTE_ADDR_RD) begin
              phase_next     = srwm_pkg::PH_BSET;
              bit_index_next = 4'd0;
              shift_reg_next = srwm_pkg::byte_value(byte_index_next, slave_address,
                                                    command_code);
            end else begin
              phase_next = srwm_pkg::PH_SA;
            end
          end
        endcase
      end
    end
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= srwm_pkg::PH_IDLE;
      stop_mode    <= srwm_pkg::STOP_FINAL;
      tick_count   <= '0;
      bit_index    <= 4'd0;
      byte_index   <= 3'd0;
      shift_reg    <= 8'h00;
      retries_left <= 8'd0;
      low_byte     <= 8'h00;
      high_byte    <= 8'h00;
      pec_byte     <= 8'h00;
      nack_flag    <= 1'b0;
    end else if (s_accept) begin
      phase        <= phase_next;
      stop_mode    <= stop_mode_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      byte_index   <= byte_index_next;
      shift_reg    <= shift_reg_next;
      retries_left <= retries_left_next;
      low_byte     <= low_byte_next;
      high_byte    <= high_byte_next;
      pec_byte     <= pec_byte_next;
      nack_flag    <= nack_flag_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_axis_tdata <= {4'd0, nack_flag_next, pec_byte_next, high_byte_next, low_byte_next,
                       res_busy, res_sda, res_scl};
      m_axis_tlast <= res_done;
    end
  end

  // checks
  `SRWM_ASSERT_IMP(a_idle_byte_pos, clk, rst, (phase == srwm_pkg::PH_IDLE), (byte_index == srwm_pkg::BYTE_ADDR_WR || byte_index == srwm_pkg::BYTE_END))
  `SRWM_ASSERT_NEXT(a_done_to_idle, clk, rst, (s_accept && res_done), (phase == srwm_pkg::PH_IDLE))
  `SRWM_ASSERT_NEXT(a_accept_gives_result, clk, rst, s_accept, (m_axis_tvalid && m_axis_tdata[2] == $past(res_busy)))

endmodule

`default_nettype wire
